// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file ist_checker.sv
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define IST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ist check failed");

// implication with a same-cycle consequent
`define IST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ist check failed");

// implication with a next-cycle consequent
`define IST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ist check failed");

`endif

// ----- rtl/ist_pkg.sv -----
// shared constants for the integer set table
// no dependencies
`default_nettype none

package ist_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int VALUE_W       = 32;
    localparam int FUNC_W        = 2;
    localparam int ELEM_COUNT_W  = 7;
    localparam int IN_TDATA_W    = 32;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_QUERY  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/integer_set_table_top.sv -----
// integer set table: top level with scan sequencer and element counter
// depends on ist_pkg and ist_ram
`default_nettype none

// Fixed-capacity set of signed 32-bit integers held in one synchronous ram
// of CAPACITY entries, each entry a valid mark beside a value. An input beat
// carries the operation in tuser (insert, remove, query; code 3 acts as a
// query) and the value in tdata. The block works on one beat at a time: it
// reads every entry of the ram in turn, one per cycle, noting the entry that
// holds the value and the lowest free entry, then does at most one write back
// and loads the result register. After acceptance the sequencer steps through
// the scan state, a last state in which the final read returns, and the apply
// state; it takes no new beat until it is idle again. A new beat is taken as
// soon as the sequencer is idle, even while the previous result still waits
// in the output register; its own result then waits until that register is
// free. After reset the block runs a clearing pass that zeroes every entry;
// tready stays low until it ends. The result gives whether the value was
// present before the operation, whether an insert of an absent value was
// refused because the set was full, and the element count after the
// operation (its low 7 bits when CAPACITY exceeds 127).

module integer_set_table_top #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] value
    input  wire logic [ist_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] func
    input  wire logic [ist_pkg::IN_TUSER_W-1:0]  s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] was_member, [1] rejected_full, [8:2] element_count, [15:9] zero
    output logic      [ist_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int VW    = ist_pkg::VALUE_W;
    localparam int EW    = ist_pkg::ELEM_COUNT_W;
    localparam int RAM_W = VW + 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;

    logic [2:0]    state_reg,     state_next;
    logic [AW-1:0] addr_reg,      addr_next;
    logic          pend_reg,      pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          hit_reg,       hit_next;
    logic [AW-1:0] hit_idx_reg,   hit_idx_next;
    logic          free_reg,      free_next;
    logic [AW-1:0] free_idx_reg,  free_idx_next;
    logic [CW-1:0] count_reg,     count_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [ist_pkg::FUNC_W-1:0]      func_reg,     func_next;
    logic [VW-1:0]                   value_reg,    value_next;
    logic [ist_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // ram ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;

    // result pieces
    logic             res_full;
    logic [CW+EW-1:0] count_wide;
    logic             load_out;

    ist_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY)
    ) u_ist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // count after the operation, cut or padded to the result field
    assign count_wide = {{EW{1'b0}}, count_next};

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = addr_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;
        res_full       = 1'b0;
        load_out       = 1'b0;

        // look at the entry read in the previous cycle
        if (pend_reg)
        begin
            if (ram_rdata[VW] && (ram_rdata[VW-1:0] == value_reg))
            begin
                hit_next     = 1'b1;
                hit_idx_next = pend_addr_reg;
            end
            if (!ram_rdata[VW] && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = pend_addr_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = s_axis_tuser;
                    value_next = s_axis_tdata[VW-1:0];
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    addr_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_LAST;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out = 1'b1;
                    case (func_reg)
                        ist_pkg::OP_INSERT:
                        begin
                            if (!hit_reg)
                            begin
                                if ((count_reg < CAP_COUNT) && free_reg)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = free_idx_reg;
                                    ram_wdata  = {1'b1, value_reg};
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    res_full = 1'b1;
                                end
                            end
                        end
                        ist_pkg::OP_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx_reg;
                                ram_wdata = {1'b0, value_reg};
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // query and the unused code change nothing
                        end
                    endcase
                    out_data_next = {{(ist_pkg::OUT_TDATA_W - EW - 2){1'b0}},
                                     count_wide[EW-1:0], res_full, hit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- rtl/ist_ram.sv -----
// generic single-clock ram, one write port, one registered read port
// no dependencies
`default_nettype none

module ist_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/ist_checker.sv -----
// port-level checks for the integer set table, bound to the top level
// depends on ist_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ist_checker #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ist_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [31:0] CAP_V = 32'(CAPACITY);
    localparam logic        CAP_SMALL = (CAPACITY < 128);

    logic in_beat;
    logic small_cap;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign small_cap = CAP_SMALL;

    // a held result does not change under backpressure
    `IST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

    // one beat in flight: the scan starts right after acceptance
    `IST_ASSERT_NEXT(a_one_at_a_time, in_beat, !s_axis_tready)

    // a refused insert never concerns a present value
    `IST_ASSERT_IMPL(a_full_not_member, m_axis_tvalid && m_axis_tdata[1],
                     !m_axis_tdata[0])

    // a refused insert reports a full set (checked for capacities below 128)
    `IST_ASSERT_IMPL(a_full_count, m_axis_tvalid && m_axis_tdata[1] && small_cap,
                     m_axis_tdata[8:2] == CAP_V[6:0])

    // the count never exceeds the capacity (checked for capacities below 128)
    `IST_ASSERT_IMPL(a_count_range, m_axis_tvalid && small_cap,
                     m_axis_tdata[8:2] <= CAP_V[6:0])

endmodule

bind integer_set_table_top ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (.*);

`default_nettype wire
